// ----- design/owas_pkg.sv -----
`default_nettype none
package owas_pkg;

  localparam int MAX_SPHERES_DEF = 16;
  localparam int ONE_Q16 = 65536;

  // register indexes
  localparam logic [1:0] REG_SPHERE_COUNT = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HALF_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_HALF_DEPTH   = 2'd3;

  localparam logic [22:0] HALF_RESET = 23'd655360;

  typedef struct packed {
    logic               kind;
    logic [3:0]         slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [22:0]        sphere_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] steer_x;
    logic signed [31:0] steer_y;
    logic signed [31:0] steer_z;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_SQUARE, ST_SUM, ST_SQRT_GO, ST_SQRT_WAIT,
    ST_CHECK, ST_TDIV_GO, ST_TDIV_WAIT, ST_CUBE1, ST_CUBE2, ST_AXIS_MUL,
    ST_AXIS_GO, ST_AXIS_WAIT, ST_NEXT, ST_WALL_MUL, ST_WALL_SUM, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CAPTURE, OP_READ, OP_DIFF, OP_SQUARE, OP_SUM,
    OP_SQRT_GO, OP_SQRT_TAKE, OP_TDIV_GO, OP_TDIV_TAKE, OP_CUBE1, OP_CUBE2,
    OP_AXIS_MUL, OP_AXIS_GO, OP_AXIS_ACC, OP_NEXT, OP_WALL_MUL, OP_WALL_SUM,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic skip;
    logic last_sphere;
    logic no_spheres;
    logic axis_last;
  } status_t;

endpackage
`default_nettype wire

// ----- design/owas_sqrt.sv -----
`default_nettype none
module owas_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [49:0] radicand,
  output logic             done,
  output logic [24:0]      root
);

  logic [49:0] rad_r, rad_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [24:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [27:0] trial_rem;
  logic [27:0] trial;

  // one root bit per cycle
  always_comb begin
    trial_rem = {rem_r, rad_r[49:48]};
    trial     = {1'b0, root_r, 2'b01};
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (go) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd24;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = {rad_r[47:0], 2'b00};
      if (trial_rem >= trial) begin
        rem_nxt  = 26'(trial_rem - trial);
        root_nxt = {root_r[23:0], 1'b1};
      end else begin
        rem_nxt  = trial_rem[25:0];
        root_nxt = {root_r[23:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ----- design/owas_div.sv -----
`default_nettype none
module owas_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [47:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic [47:0]      quot
);

  logic [47:0] nq_r, nq_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [23:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [24:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, nq_r[47]};
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      nq_nxt  = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = 6'd47;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 24'(trial - {1'b0, den_r});
        nq_nxt  = {nq_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[23:0];
        nq_nxt  = {nq_r[46:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule
`default_nettype wire

// ----- design/owas_ctrl.sv -----
`default_nettype none
module owas_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             kind,
  input  wire owas_pkg::status_t stat,
  output owas_pkg::cmd_t        cmd,
  output logic                  busy
);

  owas_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      owas_pkg::ST_IDLE:
        if (start && kind) begin
          state_nxt = stat.no_spheres ? owas_pkg::ST_WALL_MUL : owas_pkg::ST_READ;
        end
      owas_pkg::ST_READ:      state_nxt = owas_pkg::ST_DIFF;
      owas_pkg::ST_DIFF:      state_nxt = owas_pkg::ST_SQUARE;
      owas_pkg::ST_SQUARE:    state_nxt = owas_pkg::ST_SUM;
      owas_pkg::ST_SUM:       state_nxt = owas_pkg::ST_SQRT_GO;
      owas_pkg::ST_SQRT_GO:   state_nxt = owas_pkg::ST_SQRT_WAIT;
      owas_pkg::ST_SQRT_WAIT:
        if (stat.sqrt_done) begin
          state_nxt = owas_pkg::ST_CHECK;
        end
      owas_pkg::ST_CHECK:
        state_nxt = stat.skip ? owas_pkg::ST_NEXT : owas_pkg::ST_TDIV_GO;
      owas_pkg::ST_TDIV_GO:   state_nxt = owas_pkg::ST_TDIV_WAIT;
      owas_pkg::ST_TDIV_WAIT:
        if (stat.div_done) begin
          state_nxt = owas_pkg::ST_CUBE1;
        end
      owas_pkg::ST_CUBE1:     state_nxt = owas_pkg::ST_CUBE2;
      owas_pkg::ST_CUBE2:     state_nxt = owas_pkg::ST_AXIS_MUL;
      owas_pkg::ST_AXIS_MUL:  state_nxt = owas_pkg::ST_AXIS_GO;
      owas_pkg::ST_AXIS_GO:   state_nxt = owas_pkg::ST_AXIS_WAIT;
      owas_pkg::ST_AXIS_WAIT:
        if (stat.div_done) begin
          state_nxt = stat.axis_last ? owas_pkg::ST_NEXT : owas_pkg::ST_AXIS_MUL;
        end
      owas_pkg::ST_NEXT:
        state_nxt = stat.last_sphere ? owas_pkg::ST_WALL_MUL : owas_pkg::ST_READ;
      owas_pkg::ST_WALL_MUL:  state_nxt = owas_pkg::ST_WALL_SUM;
      owas_pkg::ST_WALL_SUM:  state_nxt = owas_pkg::ST_EMIT;
      owas_pkg::ST_EMIT:      state_nxt = owas_pkg::ST_IDLE;
      default:                state_nxt = owas_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op = owas_pkg::OP_NONE;
    unique case (state_r)
      owas_pkg::ST_IDLE:
        if (start) begin
          cmd.op = kind ? owas_pkg::OP_CAPTURE : owas_pkg::OP_LOAD;
        end
      owas_pkg::ST_READ:      cmd.op = owas_pkg::OP_READ;
      owas_pkg::ST_DIFF:      cmd.op = owas_pkg::OP_DIFF;
      owas_pkg::ST_SQUARE:    cmd.op = owas_pkg::OP_SQUARE;
      owas_pkg::ST_SUM:       cmd.op = owas_pkg::OP_SUM;
      owas_pkg::ST_SQRT_GO:   cmd.op = owas_pkg::OP_SQRT_GO;
      owas_pkg::ST_SQRT_WAIT:
        if (stat.sqrt_done) begin
          cmd.op = owas_pkg::OP_SQRT_TAKE;
        end
      owas_pkg::ST_CHECK:     cmd.op = owas_pkg::OP_NONE;
      owas_pkg::ST_TDIV_GO:   cmd.op = owas_pkg::OP_TDIV_GO;
      owas_pkg::ST_TDIV_WAIT:
        if (stat.div_done) begin
          cmd.op = owas_pkg::OP_TDIV_TAKE;
        end
      owas_pkg::ST_CUBE1:     cmd.op = owas_pkg::OP_CUBE1;
      owas_pkg::ST_CUBE2:     cmd.op = owas_pkg::OP_CUBE2;
      owas_pkg::ST_AXIS_MUL:  cmd.op = owas_pkg::OP_AXIS_MUL;
      owas_pkg::ST_AXIS_GO:   cmd.op = owas_pkg::OP_AXIS_GO;
      owas_pkg::ST_AXIS_WAIT:
        if (stat.div_done) begin
          cmd.op = owas_pkg::OP_AXIS_ACC;
        end
      owas_pkg::ST_NEXT:      cmd.op = owas_pkg::OP_NEXT;
      owas_pkg::ST_WALL_MUL:  cmd.op = owas_pkg::OP_WALL_MUL;
      owas_pkg::ST_WALL_SUM:  cmd.op = owas_pkg::OP_WALL_SUM;
      owas_pkg::ST_EMIT:      cmd.op = owas_pkg::OP_EMIT;
      default:                cmd.op = owas_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= owas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != owas_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ----- design/owas_dp.sv -----
`default_nettype none
module owas_dp #(
  parameter int MAX_SPHERES = owas_pkg::MAX_SPHERES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire owas_pkg::cmd_t     cmd,
  input  wire owas_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [22:0]        cfg_data,
  output owas_pkg::status_t       stat,
  output logic                    out_valid,
  output owas_pkg::out_item_t     out_data
);

  localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);
  localparam logic [8:0] MAX_N = 9'(MAX_SPHERES);
  localparam logic signed [25:0] ONE = 26'(owas_pkg::ONE_Q16);
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  // sphere table
  logic signed [23:0] cx_mem [MAX_SPHERES];
  logic signed [23:0] cy_mem [MAX_SPHERES];
  logic signed [23:0] cz_mem [MAX_SPHERES];
  logic [22:0]        rad_mem [MAX_SPHERES];

  // configuration
  logic [4:0]  count_r;
  logic [22:0] hw_r, hh_r, hd_r;

  // working registers
  logic [CNT_W-1:0]   idx_r;
  logic [1:0]         axis_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic signed [23:0] cx_r, cy_r, cz_r;
  logic [22:0]        r_r;
  logic signed [24:0] dx_r, dy_r, dz_r;
  logic [47:0]        sqx_r, sqy_r, sqz_r;
  logic [49:0]        sq_r;
  logic [24:0]        d_r;
  logic [17:0]        t_r;
  logic [35:0]        t2_r;
  logic [19:0]        p_r;
  logic [44:0]        pm_r;
  logic               neg_r;
  logic signed [35:0] acc_r [3];
  logic [47:0]        wp_r [3];
  logic [47:0]        wn_r [3];
  logic               out_valid_r;
  owas_pkg::out_item_t out_data_r;

  // root unit and shared divider
  logic        sqrt_go, sqrt_done, div_go, div_done;
  logic [24:0] sqrt_root;
  logic [47:0] div_num, div_quot;
  logic [23:0] div_den;

  owas_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sqrt_go), .radicand(sq_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  owas_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  // sphere count clamp and loop end
  logic [8:0]         n_used;
  logic [8:0]         idx_inc;
  logic [8:0]         slot_ext;
  logic [23:0]        two_r;
  logic signed [24:0] dsel;
  logic [24:0]        mag;
  logic signed [35:0] q_s;
  logic signed [35:0] acc_add;

  always_comb begin
    n_used   = ({4'd0, count_r} > MAX_N) ? MAX_N : {4'd0, count_r};
    idx_inc  = 9'(idx_r) + 9'd1;
    slot_ext = {5'd0, in_data.slot};
    two_r    = {r_r, 1'b0};
    stat.sqrt_done   = sqrt_done;
    stat.div_done    = div_done;
    stat.skip        = (d_r == '0) || (r_r == '0) || (d_r >= {1'b0, two_r});
    stat.last_sphere = (idx_inc == n_used);
    stat.no_spheres  = (n_used == 9'd0);
    stat.axis_last   = (axis_r == 2'd2);
  end

  // per-axis selection
  always_comb begin
    unique case (axis_r)
      2'd0:    dsel = dx_r;
      2'd1:    dsel = dy_r;
      default: dsel = dz_r;
    endcase
    mag     = dsel[24] ? 25'(-dsel) : 25'(dsel);
    q_s     = signed'({16'd0, div_quot[19:0]});
    acc_add = neg_r ? -q_s : q_s;
  end

  // divider and root start
  always_comb begin
    sqrt_go = (cmd.op == owas_pkg::OP_SQRT_GO);
    div_go  = (cmd.op == owas_pkg::OP_TDIV_GO) || (cmd.op == owas_pkg::OP_AXIS_GO);
    if (cmd.op == owas_pkg::OP_TDIV_GO) begin
      div_num = {8'd0, 24'(two_r - d_r[23:0]), 16'd0};
      div_den = {1'b0, r_r};
    end else begin
      div_num = {3'd0, pm_r};
      div_den = d_r[23:0];
    end
  end

  // wall overshoot
  logic signed [25:0] ow_p [3];
  logic signed [25:0] ow_n [3];
  logic signed [23:0] pos_a [3];
  logic [22:0]        half_a [3];

  always_comb begin
    pos_a[0] = px_r; pos_a[1] = py_r; pos_a[2] = pz_r;
    half_a[0] = hw_r; half_a[1] = hh_r; half_a[2] = hd_r;
    for (int k = 0; k < 3; k++) begin
      ow_p[k] = ONE - signed'({3'd0, half_a[k]}) - 26'(pos_a[k]);
      ow_n[k] = ONE - signed'({3'd0, half_a[k]}) + 26'(pos_a[k]);
    end
  end

  // table and configuration writes
  always_ff @(posedge clk) begin
    if (cmd.op == owas_pkg::OP_LOAD && slot_ext < MAX_N) begin
      cx_mem[slot_ext[IDX_W-1:0]]  <= in_data.pos_x;
      cy_mem[slot_ext[IDX_W-1:0]]  <= in_data.pos_y;
      cz_mem[slot_ext[IDX_W-1:0]]  <= in_data.pos_z;
      rad_mem[slot_ext[IDX_W-1:0]] <= in_data.sphere_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hw_r    <= owas_pkg::HALF_RESET;
      hh_r    <= owas_pkg::HALF_RESET;
      hd_r    <= owas_pkg::HALF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owas_pkg::REG_SPHERE_COUNT: count_r <= cfg_data[4:0];
        owas_pkg::REG_HALF_WIDTH:   hw_r    <= cfg_data;
        owas_pkg::REG_HALF_HEIGHT:  hh_r    <= cfg_data;
        default:                    hd_r    <= cfg_data;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == owas_pkg::OP_EMIT);
    end
  end

  // datapath steps
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      owas_pkg::OP_CAPTURE: begin
        px_r  <= in_data.pos_x;
        py_r  <= in_data.pos_y;
        pz_r  <= in_data.pos_z;
        idx_r <= '0;
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
      end
      owas_pkg::OP_READ: begin
        cx_r   <= cx_mem[idx_r[IDX_W-1:0]];
        cy_r   <= cy_mem[idx_r[IDX_W-1:0]];
        cz_r   <= cz_mem[idx_r[IDX_W-1:0]];
        r_r    <= rad_mem[idx_r[IDX_W-1:0]];
        axis_r <= '0;
      end
      owas_pkg::OP_DIFF: begin
        dx_r <= 25'(px_r) - 25'(cx_r);
        dy_r <= 25'(py_r) - 25'(cy_r);
        dz_r <= 25'(pz_r) - 25'(cz_r);
      end
      owas_pkg::OP_SQUARE: begin
        sqx_r <= 48'(dx_r * dx_r);
        sqy_r <= 48'(dy_r * dy_r);
        sqz_r <= 48'(dz_r * dz_r);
      end
      owas_pkg::OP_SUM:       sq_r <= 50'(sqx_r) + 50'(sqy_r) + 50'(sqz_r);
      owas_pkg::OP_SQRT_TAKE: d_r  <= sqrt_root;
      owas_pkg::OP_TDIV_TAKE: t_r  <= div_quot[17:0];
      owas_pkg::OP_CUBE1:     t2_r <= 36'(t_r) * 36'(t_r);
      owas_pkg::OP_CUBE2:     p_r  <= 20'((54'(t2_r) * 54'(t_r)) >> 32);
      owas_pkg::OP_AXIS_MUL: begin
        pm_r  <= 45'(p_r) * 45'(mag);
        neg_r <= dsel[24];
      end
      owas_pkg::OP_AXIS_ACC: begin
        acc_r[axis_r] <= acc_r[axis_r] + acc_add;
        axis_r        <= axis_r + 2'd1;
      end
      owas_pkg::OP_NEXT:      idx_r <= idx_r + CNT_W'(1);
      owas_pkg::OP_WALL_MUL: begin
        for (int k = 0; k < 3; k++) begin
          wp_r[k] <= (ow_p[k] > 0) ? 48'(ow_p[k][23:0]) * 48'(ow_p[k][23:0]) : '0;
          wn_r[k] <= (ow_n[k] > 0) ? 48'(ow_n[k][23:0]) * 48'(ow_n[k][23:0]) : '0;
        end
      end
      owas_pkg::OP_WALL_SUM: begin
        for (int k = 0; k < 3; k++) begin
          acc_r[k] <= acc_r[k] + signed'(36'(wp_r[k] >> 16))
                               - signed'(36'(wn_r[k] >> 16));
        end
      end
      owas_pkg::OP_EMIT: begin
        out_data_r.steer_x <= (acc_r[0] > SAT_HI) ? 32'(SAT_HI) :
                              (acc_r[0] < SAT_LO) ? 32'(SAT_LO) : acc_r[0][31:0];
        out_data_r.steer_y <= (acc_r[1] > SAT_HI) ? 32'(SAT_HI) :
                              (acc_r[1] < SAT_LO) ? 32'(SAT_LO) : acc_r[1][31:0];
        out_data_r.steer_z <= (acc_r[2] > SAT_HI) ? 32'(SAT_HI) :
                              (acc_r[2] < SAT_LO) ? 32'(SAT_LO) : acc_r[2][31:0];
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- design/obstacle_wall_avoid_steer.sv -----
// Obstacle and wall avoidance steering.
// Input channel: present in_data with start; the item is taken on a clock
// edge where start is high and busy is low. kind 0 loads a sphere (center,
// radius) into table slot "slot" with no result; kind 1 is a
// query returning one steering vector on out_data, with out_valid high for
// exactly one cycle. The receiver cannot stall; results must be taken as shown.
// Configuration: cfg_valid/cfg_ready write channel (cfg_ready always high),
// cfg_index 0 sphere count, 1..3 half extents x/y/z; write only while idle.
// A query walks the used spheres in turn: each gets a root search (25 steps) on
// the bit-serial root unit, and a contributing one also gets the radius ratio and
// the three vector components on the one-bit-per-cycle divider shared by them.
// The wall terms follow. One item is worked on at a time.
// Reset: sphere count 0, extents 10.0; the sphere table keeps no reset value
// and every slot a query reads must be loaded first.
`default_nettype none
module obstacle_wall_avoid_steer #(
  parameter int MAX_SPHERES = owas_pkg::MAX_SPHERES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire owas_pkg::in_item_t in_data,
  output logic                    out_valid,
  output owas_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [22:0]        cfg_data
);

  owas_pkg::cmd_t    cmd;
  owas_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  owas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_data.kind),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  owas_dp #(.MAX_SPHERES(MAX_SPHERES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;

  // expected steering vectors, computed from a private copy of table and registers
  class steer_scoreboard;
    logic [4:0]           count_reg;
    logic [22:0]          half_ext [3];
    logic signed [23:0]   cen_x [16];
    logic signed [23:0]   cen_y [16];
    logic signed [23:0]   cen_z [16];
    logic [22:0]          rad [16];
    owas_pkg::out_item_t  pending [$];
    int                   errors;

    function void reset_state();
      count_reg = 5'd0;
      for (int k = 0; k < 3; k++) half_ext[k] = owas_pkg::HALF_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [22:0] val);
      case (idx)
        owas_pkg::REG_SPHERE_COUNT: count_reg = val[4:0];
        owas_pkg::REG_HALF_WIDTH:   half_ext[0] = val;
        owas_pkg::REG_HALF_HEIGHT:  half_ext[1] = val;
        owas_pkg::REG_HALF_DEPTH:   half_ext[2] = val;
      endcase
    endfunction

    // bitwise integer square root, floor
    function longint unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // squared overshoot into the one-unit band inside a wall
    function longint wall(longint h, longint c);
      longint o;
      o = 65536 - h - c;
      if (o <= 0) return 0;
      return (o * o) >>> 16;
    endfunction

    function longint part(longint unsigned p, longint diff, longint unsigned d);
      longint unsigned mag;
      longint q;
      mag = (diff < 0) ? -diff : diff;
      q = (p * mag) / d;
      return (diff < 0) ? -q : q;
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_item(owas_pkg::in_item_t it);
      longint px, py, pz, dx, dy, dz, sx, sy, sz;
      longint unsigned r, sq, d, t, p;
      int n;
      owas_pkg::out_item_t res;
      if (it.kind == 1'b0) begin
        cen_x[it.slot] = it.pos_x;
        cen_y[it.slot] = it.pos_y;
        cen_z[it.slot] = it.pos_z;
        rad[it.slot] = it.sphere_radius;
        return;
      end
      px = it.pos_x; py = it.pos_y; pz = it.pos_z;
      sx = 0; sy = 0; sz = 0;
      n = (count_reg > 16) ? 16 : count_reg;
      // sphere contributions
      for (int i = 0; i < n; i++) begin
        dx = px - longint'(cen_x[i]);
        dy = py - longint'(cen_y[i]);
        dz = pz - longint'(cen_z[i]);
        r = rad[i];
        sq = dx * dx + dy * dy + dz * dz;
        d = root(sq);
        if (d == 0 || r == 0 || d >= 2 * r) continue;
        t = ((2 * r - d) << 16) / r;
        p = (t * t * t) >> 32;
        sx += part(p, dx, d);
        sy += part(p, dy, d);
        sz += part(p, dz, d);
      end
      // walls
      sx += wall(half_ext[0], px) - wall(half_ext[0], -px);
      sy += wall(half_ext[1], py) - wall(half_ext[1], -py);
      sz += wall(half_ext[2], pz) - wall(half_ext[2], -pz);
      res.steer_x = clamp32(sx);
      res.steer_y = clamp32(sy);
      res.steer_z = clamp32(sz);
      pending.push_back(res);
    endfunction

    function void check_result(owas_pkg::out_item_t got);
      owas_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.steer_x !== want.steer_x) begin
        $display("%0t: steer_x expected %0d actual %0d", $time, want.steer_x, got.steer_x);
        errors++;
      end
      if (got.steer_y !== want.steer_y) begin
        $display("%0t: steer_y expected %0d actual %0d", $time, want.steer_y, got.steer_y);
        errors++;
      end
      if (got.steer_z !== want.steer_z) begin
        $display("%0t: steer_z expected %0d actual %0d", $time, want.steer_z, got.steer_z);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  owas_pkg::in_item_t  in_data;
  logic                out_valid;
  owas_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [22:0]         cfg_data;

  steer_scoreboard sb;
  int idle_pct;

  obstacle_wall_avoid_steer u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // send one item, with random idle cycles before it
  task automatic send_item(owas_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic owas_pkg::in_item_t load_item(int s, int x, int y, int z, int r);
    owas_pkg::in_item_t it;
    it.kind = 1'b0;
    it.slot = 4'(s);
    it.pos_x = 24'(x); it.pos_y = 24'(y); it.pos_z = 24'(z);
    it.sphere_radius = 23'(r);
    return it;
  endfunction

  function automatic owas_pkg::in_item_t query_item(int x, int y, int z);
    owas_pkg::in_item_t it;
    it = load_item($urandom_range(15), x, y, z, $urandom);
    it.kind = 1'b1;
    return it;
  endfunction

  function automatic int near(int c, int span);
    return c + $signed($urandom_range(2 * span)) - span;
  endfunction

  // random item: loads with mostly small spheres, queries near spheres, near walls or anywhere
  function automatic owas_pkg::in_item_t rand_item();
    int s, sel, rr;
    int q [3];
    sel = $urandom_range(99);
    if (sel < 40) begin
      sel = $urandom_range(9);
      rr = (sel < 1) ? 0 : (sel < 8) ? $urandom_range(262144) : $urandom_range(8388607);
      if ($urandom_range(1))
        return load_item($urandom_range(15), $urandom, $urandom, $urandom, rr);
      return load_item($urandom_range(15), near(0, 327680), near(0, 327680),
                       near(0, 327680), rr);
    end
    sel = $urandom_range(3);
    if (sel < 2) begin
      s = $urandom_range(15);
      rr = 2 * sb.rad[s] + 1;
      if (rr > 1048576) rr = 1048576;
      return query_item(near(sb.cen_x[s], rr), near(sb.cen_y[s], rr), near(sb.cen_z[s], rr));
    end
    if (sel == 2) begin
      for (int k = 0; k < 3; k++) begin
        q[k] = near(sb.half_ext[k], 131072);
        if ($urandom_range(1)) q[k] = -q[k];
      end
      return query_item(q[0], q[1], q[2]);
    end
    return query_item($urandom, $urandom, $urandom);
  endfunction

  function automatic logic [22:0] pick_half();
    case ($urandom_range(4))
      0: return 23'd0;
      1: return 23'h7FFFFF;
      2: return owas_pkg::HALF_RESET;
      3: return 23'($urandom_range(131072));
      default: return 23'($urandom);
    endcase
  endfunction

  function automatic logic [22:0] pick_count();
    case ($urandom_range(5))
      0: return 23'd0;
      1: return 23'd16;
      2: return 23'd31;
      3: return 23'($urandom);
      default: return 23'($urandom_range(4));
    endcase
  endfunction

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = owas_pkg::REG_SPHERE_COUNT;
    cfg_data = '0;
    idle_pct = 8;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: fill the table, extremes of centers and radii
    send_item(load_item(0, 0, 0, 0, 65536));
    send_item(load_item(1, 8388607, 8388607, 8388607, 8388607));
    send_item(load_item(2, -8388608, -8388608, -8388608, 8388607));
    send_item(load_item(3, 100000, 0, 0, 0));
    for (int s = 4; s < 16; s++)
      send_item(load_item(s, near(0, 400000), near(0, 400000), near(0, 400000),
                          $urandom_range(200000)));
    // default registers (sphere count 0), point between walls
    send_item(query_item(30000, -20000, 10000));
    drain();
    write_reg(owas_pkg::REG_SPHERE_COUNT, 23'd16);
    // zero distance, zero radius sphere, table corners, wall extremes
    send_item(query_item(0, 0, 0));
    send_item(query_item(100000, 0, 0));
    send_item(query_item(8388607, 8388607, 8388607));
    send_item(query_item(-8388608, -8388608, -8388608));
    send_item(query_item(640000, -640000, 600000));
    drain();
    // small extents: both walls push; huge extents: none
    write_reg(owas_pkg::REG_HALF_WIDTH, 23'd0);
    write_reg(owas_pkg::REG_HALF_HEIGHT, 23'd20000);
    write_reg(owas_pkg::REG_HALF_DEPTH, 23'h7FFFFF);
    write_reg(owas_pkg::REG_SPHERE_COUNT, 23'd31);
    send_item(query_item(10000, -5000, 0));
    send_item(query_item(-8388608, 8388607, 3));
    drain();

    // random phases: sender idle 8%, 70%, then none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 70 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        write_reg(owas_pkg::REG_SPHERE_COUNT, pick_count());
        write_reg(owas_pkg::REG_HALF_WIDTH, pick_half());
        write_reg(owas_pkg::REG_HALF_HEIGHT, pick_half());
        write_reg(owas_pkg::REG_HALF_DEPTH, pick_half());
        for (int k = 0; k < 66; k++) send_item(rand_item());
        drain();
      end
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

endmodule
